// File: hw/rtl/cedst_pkg.sv
// Shared types and constants for the central European summer-time flag.
// Holds the reciprocal constants for the calendar split and the date record.
// No dependencies.
package cedst_pkg;

    localparam int unsigned TS_W        = 32;
    localparam int unsigned ZONE_W      = 5;
    localparam int unsigned YEAR_W      = 12;
    localparam int unsigned DAYS_W      = 16;
    localparam int unsigned SOD_W       = 17;
    localparam int unsigned HOUR_W      = 5;
    localparam int unsigned DOM_W       = 5;
    localparam int unsigned CYC_W       = 6;
    localparam int unsigned DOY_W       = 9;
    localparam int unsigned REM_W       = 11;
    localparam int unsigned HM_W        = 11;

    localparam int unsigned DAY_PRE_SHIFT = 7;
    localparam logic [25:0] DAYS_RECIP    = 26'd50903317;
    localparam int unsigned DAYS_RSHIFT   = 35;
    localparam logic [31:0] SECS_PER_DAY  = 32'd86400;
    localparam logic [15:0] HOUR_RECIP    = 16'd37283;
    localparam int unsigned HOUR_RSHIFT   = 27;

    localparam logic [15:0] EPOCH_OFFSET  = 16'd671;
    localparam logic [15:0] SKIP_DAY      = 16'd47541;
    localparam logic [15:0] CYCLE_DAYS    = 16'd1461;
    localparam logic [16:0] CYCLE_RECIP   = 17'd91868;
    localparam int unsigned CYCLE_RSHIFT  = 27;
    localparam logic [11:0] BASE_YEAR     = 12'd1968;
    localparam logic [10:0] YEAR_DAYS     = 11'd365;

    localparam logic [12:0] SEVEN_RECIP   = 13'd4682;
    localparam int unsigned SEVEN_RSHIFT  = 15;
    localparam logic [10:0] THRESH_BASE   = 11'd745;

    localparam logic signed [ZONE_W-1:0] ZONE_RESET = 5'sd1;

    // March-based month index, March first
    typedef enum logic [3:0] {
        MON_MAR, MON_APR, MON_MAY, MON_JUN, MON_JUL, MON_AUG,
        MON_SEP, MON_OCT, MON_NOV, MON_DEC, MON_JAN, MON_FEB
    } t_month;

    localparam logic [DOY_W-1:0] MONTH_START [12] = '{
        9'd0, 9'd31, 9'd61, 9'd92, 9'd122, 9'd153,
        9'd184, 9'd214, 9'd245, 9'd275, 9'd306, 9'd337
    };

    typedef struct packed {
        logic              valid;
        logic [YEAR_W-1:0] year;
        t_month            month;
        logic [DOM_W-1:0]  dom;
        logic [HOUR_W-1:0] hour;
    } t_date;

endpackage

// File: hw/rtl/cedst_date_split.sv
// Pipelined split of a Unix seconds count into year, month, day and hour.
// Uses cedst_pkg; six register stages, one request per cycle.
// Dates after the end of February 2100 are shifted one day to keep a 4-year cycle.
module cedst_date_split (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  logic [cedst_pkg::TS_W-1:0] i_unix_seconds,
    output cedst_pkg::t_date          o_date
);
    import cedst_pkg::*;

    logic [6:1] r_v;

    logic [TS_W-1:0]   r_t1;
    logic [DAYS_W-1:0] r_days;
    logic [SOD_W-1:0]  r_sod;
    logic [DAYS_W-1:0] r_e2;
    logic [HOUR_W-1:0] r_hour3;
    logic [CYC_W-1:0]  r_c3;
    logic [DAYS_W-1:0] r_e3;
    logic [HOUR_W-1:0] r_hour4;
    logic [REM_W-1:0]  r_rem4;
    logic [YEAR_W-1:0] r_ybase4;
    logic [HOUR_W-1:0] r_hour5;
    logic [DOY_W-1:0]  r_doy5;
    logic [YEAR_W-1:0] r_year5;
    logic [YEAR_W-1:0] r_year6;
    t_month            r_month6;
    logic [DOM_W-1:0]  r_dom6;
    logic [HOUR_W-1:0] r_hour6;

    logic [50:0]       n_days_prod;
    logic [DAYS_W-1:0] n_days;
    logic [TS_W-1:0]   n_sod_full;
    logic [DAYS_W-1:0] n_e;
    logic [32:0]       n_hour_prod;
    logic [32:0]       n_cyc_prod;
    logic [DAYS_W-1:0] n_rem_full;
    logic [YEAR_W-1:0] n_ybase;
    logic [1:0]        n_yoff;
    logic [REM_W-1:0]  n_doy_full;
    logic [3:0]        n_mcnt;
    t_month            n_month;
    logic [DOY_W-1:0]  n_dom_full;

    always_comb begin
        n_days_prod = 51'(i_unix_seconds[TS_W-1:DAY_PRE_SHIFT]) * 51'(DAYS_RECIP);
        n_days      = n_days_prod[DAYS_RSHIFT +: DAYS_W];
        n_sod_full  = r_t1 - 32'(r_days) * SECS_PER_DAY;
        n_e         = r_days + EPOCH_OFFSET + 16'(r_days >= SKIP_DAY);
        n_hour_prod = 33'(r_sod) * 33'(HOUR_RECIP);
        n_cyc_prod  = 33'(r_e2) * 33'(CYCLE_RECIP);
        n_rem_full  = r_e3 - 16'(r_c3) * CYCLE_DAYS;
        n_ybase     = BASE_YEAR + 12'({r_c3, 2'b00});
        n_yoff      = 2'(r_rem4 >= YEAR_DAYS) + 2'(r_rem4 >= 11'd730)
                    + 2'(r_rem4 >= 11'd1095);
        n_doy_full  = r_rem4 - 11'(n_yoff) * YEAR_DAYS;
    end

    always_comb begin
        n_mcnt = 4'd0;
        for (int k = 1; k < 12; k++) begin
            n_mcnt = n_mcnt + 4'(r_doy5 >= MONTH_START[k]);
        end
        n_month    = t_month'(n_mcnt);
        n_dom_full = r_doy5 - MONTH_START[n_mcnt] + 9'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[5:1], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r_t1     <= i_unix_seconds;
        r_days   <= n_days;
        r_sod    <= n_sod_full[SOD_W-1:0];
        r_e2     <= n_e;
        r_hour3  <= n_hour_prod[HOUR_RSHIFT +: HOUR_W];
        r_c3     <= n_cyc_prod[CYCLE_RSHIFT +: CYC_W];
        r_e3     <= r_e2;
        r_hour4  <= r_hour3;
        r_rem4   <= n_rem_full[REM_W-1:0];
        r_ybase4 <= n_ybase;
        r_hour5  <= r_hour4;
        r_doy5   <= n_doy_full[DOY_W-1:0];
        r_year5  <= r_ybase4 + 12'(n_yoff);
        r_year6  <= r_year5;
        r_month6 <= n_month;
        r_dom6   <= n_dom_full[DOM_W-1:0];
        r_hour6  <= r_hour5;
    end

    assign o_date = {r_v[6], r_year6, r_month6, r_dom6, r_hour6};

endmodule

// File: hw/rtl/central_europe_dst_flag.sv
// Central European summer-time flag from a Unix seconds count.
// A request is registered in r_v0, passes through the date split and then r_v7 and r_v8; r_v8 drives o_result_valid.
// Throughput: one request per cycle, set by the 9-stage pipeline; busy stays low.
// Reset clears the pipeline valid bits and sets the zone offset to +1 hour.
// Depends on cedst_pkg and cedst_date_split.
module central_europe_dst_flag (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic [cedst_pkg::TS_W-1:0]            i_unix_seconds,
    output logic                                  o_result_valid,
    output logic                                  o_summer_time,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic signed [cedst_pkg::ZONE_W-1:0]   i_zone_offset_hours
);
    import cedst_pkg::*;

    logic                     r_v0;
    logic [TS_W-1:0]          r_t0;
    logic signed [ZONE_W-1:0] r_zone;
    t_date                    date;

    logic                     r_v7;
    logic [YEAR_W-1:0]        r_w7;
    logic [9:0]               r_q7;
    logic [HM_W-1:0]          r_hm7;
    t_month                   r_month7;
    logic                     r_v8;
    logic                     r_flag8;

    logic [13:0]              n_y5;
    logic [24:0]              n_q_prod;
    logic [YEAR_W-1:0]        n_a_full;
    logic [2:0]               n_a;
    logic [2:0]               n_km;
    logic [2:0]               n_ko;
    logic [HM_W-1:0]          n_zone_ext;
    logic [HM_W-1:0]          n_th_mar;
    logic [HM_W-1:0]          n_th_oct;
    logic                     n_flag;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0   <= 1'b0;
            r_v7   <= 1'b0;
            r_v8   <= 1'b0;
            r_zone <= ZONE_RESET;
        end else begin
            r_v0 <= start && !busy;
            r_v7 <= date.valid;
            r_v8 <= r_v7;
            if (i_cfg_valid && o_cfg_ready) begin
                r_zone <= i_zone_offset_hours;
            end
        end
    end

    cedst_date_split u_date (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (r_v0),
        .i_unix_seconds (r_t0),
        .o_date         (date)
    );

    always_comb begin
        n_y5     = 14'(date.year) * 14'd5;
        n_q_prod = 25'(n_y5[13:2]) * 25'(SEVEN_RECIP);
    end

    always_comb begin
        n_a_full   = r_w7 - 12'(r_q7) * 12'd7;
        n_a        = n_a_full[2:0];
        n_km       = (n_a >= 3'd3) ? n_a - 3'd3 : n_a + 3'd4;
        n_ko       = (n_a == 3'd6) ? 3'd0 : n_a + 3'd1;
        n_zone_ext = {{(HM_W-ZONE_W){r_zone[ZONE_W-1]}}, r_zone};
        n_th_mar   = THRESH_BASE + n_zone_ext - 11'(n_km) * 11'd24;
        n_th_oct   = THRESH_BASE + n_zone_ext - 11'(n_ko) * 11'd24;
        priority if (r_month7 == MON_MAR) begin
            n_flag = (r_hm7 >= n_th_mar);
        end else if (r_month7 == MON_OCT) begin
            n_flag = (r_hm7 < n_th_oct);
        end else begin
            n_flag = (r_month7 > MON_MAR) && (r_month7 < MON_OCT);
        end
    end

    always_ff @(posedge i_clk) begin
        r_t0     <= i_unix_seconds;
        r_w7     <= n_y5[13:2];
        r_q7     <= n_q_prod[SEVEN_RSHIFT +: 10];
        r_hm7    <= 11'(date.dom) * 11'd24 + 11'(date.hour);
        r_month7 <= date.month;
        r_flag8  <= n_flag;
    end

    assign o_result_valid = r_v8;
    assign o_summer_time  = r_flag8;

endmodule
